>>> rtl/core/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared constants, request codes and types of the bitstream reader.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int BufferDepth = 16;
    localparam int CntW        = $clog2(BufferDepth + 1);
    localparam int IdxW        = $clog2(BufferDepth);
    localparam int AvailW      = CntW + 3;
    localparam int WinBytes    = 9;
    localparam int WinW        = WinBytes * 8;

    localparam logic [2:0] REQ_PUSH  = 3'd0;
    localparam logic [2:0] REQ_BITS  = 3'd1;
    localparam logic [2:0] REQ_UE    = 3'd2;
    localparam logic [2:0] REQ_SE    = 3'd3;
    localparam logic [2:0] REQ_ESIZE = 3'd4;
    localparam logic [2:0] REQ_EID   = 3'd5;
    localparam logic [2:0] REQ_BAD   = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MORE   = 2'd1;
    localparam logic [1:0] ST_BROKEN = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [7:0] EMU_BYTE = 8'h03;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [6:0] bit_count;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
        logic [31:0] signed_value;
        logic        byte_removed;
    } t_res;

    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd32;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 6'(31 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [3:0] lzc8(input logic [7:0] v);
        logic [3:0] n;
        logic       found;
        n     = 4'd8;
        found = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 4'(7 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/core/bsr_front.sv
// ----------------------------------------------------------------------------
// bsr_front
// Accepts requests, classifies the request type, holds a two-entry queue.
// ----------------------------------------------------------------------------
module bsr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_req_type,
    input  logic [7:0]    i_data_byte,
    input  logic [6:0]    i_bit_count,
    output logic          o_req_valid,
    output bsr_pkg::t_req o_req,
    input  logic          i_req_pop
);

    bsr_pkg::t_req r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;
    bsr_pkg::t_req w_in;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_req_pop && o_req_valid;

    always_comb begin
        w_in.data_byte = i_data_byte;
        w_in.bit_count = i_bit_count;
        case (i_req_type)
            bsr_pkg::REQ_PUSH:  w_in.kind = bsr_pkg::REQ_PUSH;
            bsr_pkg::REQ_BITS:  w_in.kind = bsr_pkg::REQ_BITS;
            bsr_pkg::REQ_UE:    w_in.kind = bsr_pkg::REQ_UE;
            bsr_pkg::REQ_SE:    w_in.kind = bsr_pkg::REQ_SE;
            bsr_pkg::REQ_ESIZE: w_in.kind = bsr_pkg::REQ_ESIZE;
            bsr_pkg::REQ_EID:   w_in.kind = bsr_pkg::REQ_EID;
            default:            w_in.kind = bsr_pkg::REQ_BAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_in;
    end

endmodule

>>> rtl/core/bsr_back.sv
// ----------------------------------------------------------------------------
// bsr_back
// Byte queue, bit window, exp-Golomb / EBML decode and result register.
// ----------------------------------------------------------------------------
module bsr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_h26x_mode,
    input  logic          i_req_valid,
    input  bsr_pkg::t_req i_req,
    output logic          o_req_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output bsr_pkg::t_res o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WIN  = 2'd1;
    localparam logic [1:0] S_LZ   = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [7:0]                  r_q [bsr_pkg::BufferDepth];
    logic [7:0]                  n_q [bsr_pkg::BufferDepth];
    logic [bsr_pkg::CntW-1:0]    r_cnt, n_cnt;
    logic [2:0]                  r_bitpos, n_bitpos;
    logic [1:0]                  r_zrun, n_zrun;
    bsr_pkg::t_req               r_req;
    logic [bsr_pkg::WinW-1:0]    r_win;
    logic [bsr_pkg::AvailW-1:0]  r_avail;
    logic [5:0]                  r_z;
    logic                        r_out_valid, n_out_valid;
    bsr_pkg::t_res               r_out, n_out;

    logic [bsr_pkg::WinW-1:0]    w_win0;
    logic [bsr_pkg::AvailW-1:0]  w_avail;
    logic [bsr_pkg::AvailW-1:0]  w_limit;
    logic [5:0]                  w_lz;
    logic                        w_fire;

    assign o_valid   = r_out_valid;
    assign o_res     = r_out;
    assign o_req_pop = (r_state == S_IDLE) && i_req_valid;
    assign w_fire    = (r_state == S_EXEC) && (!r_out_valid || i_ready);

    always_comb begin
        for (int i = 0; i < bsr_pkg::WinBytes; i++) begin
            w_win0[bsr_pkg::WinW-1-8*i -: 8] = r_q[i];
        end
        w_avail = (r_cnt == '0) ? '0
                : ({r_cnt, 3'b000} - bsr_pkg::AvailW'(r_bitpos));
        w_lz    = bsr_pkg::lzc32(r_win[bsr_pkg::WinW-1 -: 32]);
        w_limit = (r_avail < bsr_pkg::AvailW'(32)) ? r_avail : bsr_pkg::AvailW'(32);
    end

    always_comb begin
        logic [63:0] top64;
        logic [6:0]  consume;
        logic        do_consume;
        logic [7:0]  off;
        logic [3:0]  pops;
        logic [6:0]  twoz1;
        logic [63:0] v;
        logic [31:0] half;
        logic [3:0]  elen;
        logic [6:0]  ebits;
        logic [5:0]  emask_w;

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_bitpos    = r_bitpos;
        n_zrun      = r_zrun;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        for (int i = 0; i < bsr_pkg::BufferDepth; i++) n_q[i] = r_q[i];

        top64      = r_win[bsr_pkg::WinW-1 -: 64];
        consume    = '0;
        do_consume = 1'b0;
        off        = '0;
        pops       = '0;
        twoz1      = {r_z, 1'b1};
        v          = (top64 << r_z) >> (7'd63 - {1'b0, r_z});
        half       = {1'b0, v[31:1]};
        elen       = bsr_pkg::lzc8(r_q[0]) + 4'd1;
        ebits      = {elen[3:0], 3'b000};
        emask_w    = 6'(7 * elen);

        case (r_state)
            S_IDLE: if (i_req_valid) n_state = S_WIN;
            S_WIN:  n_state = S_LZ;
            S_LZ:   n_state = S_EXEC;
            S_EXEC: if (w_fire) begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_out       = '0;
                n_out.status = bsr_pkg::ST_OK;
                case (r_req.kind)
                    bsr_pkg::REQ_PUSH: begin
                        if (i_h26x_mode && r_zrun == 2'd2
                            && r_req.data_byte == bsr_pkg::EMU_BYTE) begin
                            n_out.byte_removed = 1'b1;
                            n_zrun = 2'd0;
                        end else if (r_cnt >= bsr_pkg::CntW'(bsr_pkg::BufferDepth)) begin
                            n_out.status = bsr_pkg::ST_FULL;
                        end else begin
                            n_q[r_cnt[bsr_pkg::IdxW-1:0]] = r_req.data_byte;
                            n_cnt = r_cnt + 1'b1;
                            if (r_req.data_byte == 8'd0)
                                n_zrun = (r_zrun < 2'd2) ? r_zrun + 2'd1 : 2'd2;
                            else
                                n_zrun = 2'd0;
                        end
                    end
                    bsr_pkg::REQ_BITS: begin
                        if (r_req.bit_count > 7'd64) begin
                            n_out.status = bsr_pkg::ST_BROKEN;
                        end else if (bsr_pkg::AvailW'(r_req.bit_count) > r_avail) begin
                            n_out.status = bsr_pkg::ST_MORE;
                        end else begin
                            n_out.value = top64 >> (7'd64 - r_req.bit_count);
                            consume     = r_req.bit_count;
                            do_consume  = 1'b1;
                        end
                    end
                    bsr_pkg::REQ_UE, bsr_pkg::REQ_SE: begin
                        if (r_z >= 6'd32) begin
                            n_out.status = bsr_pkg::ST_BROKEN;
                        end else if (bsr_pkg::AvailW'(twoz1) > r_avail) begin
                            n_out.status = bsr_pkg::ST_MORE;
                        end else begin
                            n_out.value = v - 64'd1;
                            if (r_req.kind == bsr_pkg::REQ_SE)
                                n_out.signed_value = v[0] ? (32'd0 - half) : half;
                            consume    = twoz1;
                            do_consume = 1'b1;
                        end
                    end
                    bsr_pkg::REQ_ESIZE, bsr_pkg::REQ_EID: begin
                        if (r_cnt == '0) begin
                            n_out.status = bsr_pkg::ST_MORE;
                        end else if (r_bitpos != 3'd0 || r_q[0] == 8'd0) begin
                            n_out.status = bsr_pkg::ST_BROKEN;
                        end else if (bsr_pkg::CntW'(elen) > r_cnt) begin
                            n_out.status = bsr_pkg::ST_MORE;
                        end else begin
                            n_out.value = top64 >> (7'd64 - ebits);
                            if (r_req.kind == bsr_pkg::REQ_ESIZE)
                                n_out.value = n_out.value & ((64'd1 << emask_w) - 64'd1);
                            consume    = ebits;
                            do_consume = 1'b1;
                        end
                    end
                    default: n_out.status = bsr_pkg::ST_BROKEN;
                endcase

                off  = {5'd0, r_bitpos} + {1'b0, consume};
                pops = off[6:3];
                if (do_consume) begin
                    n_bitpos = off[2:0];
                    n_cnt    = r_cnt - bsr_pkg::CntW'(pops);
                    for (int i = 0; i < bsr_pkg::BufferDepth; i++) begin
                        for (int p = 1; p <= 8; p++) begin
                            if (pops == 4'(p) && i + p < bsr_pkg::BufferDepth)
                                n_q[i] = r_q[i + p];
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_bitpos    <= 3'd0;
            r_zrun      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_bitpos    <= n_bitpos;
            r_zrun      <= n_zrun;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < bsr_pkg::BufferDepth; i++) r_q[i] <= n_q[i];
        r_out <= n_out;
        if (o_req_pop) r_req <= i_req;
        if (r_state == S_WIN) begin
            r_win   <= w_win0 << r_bitpos;
            r_avail <= w_avail;
        end
        if (r_state == S_LZ)
            r_z <= (bsr_pkg::AvailW'(w_lz) < w_limit) ? w_lz : 6'(w_limit);
    end

endmodule

>>> rtl/core/bitstream_reader_expgolomb_core.sv
// ----------------------------------------------------------------------------
// bitstream_reader_expgolomb_core
// Bit reader with emulation prevention removal, exp-Golomb and EBML decode.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// request   in         i_valid / o_ready  i_req_type, i_data_byte, i_bit_count
// result    out        o_valid / i_ready  o_status, o_value, o_signed_value,
//                                         o_byte_removed
// config    in         i_cfg_we           i_cfg_wdata (h26x mode)
//
// In the back end each transaction goes through request pop, window align,
// leading-zero search and execute; the result is valid the cycle after execute.
// Execute waits while the result register holds an untaken result; the
// two-entry request queue then fills and drops o_ready.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module bitstream_reader_expgolomb_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic [6:0]  i_bit_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_value,
    output logic signed [31:0] o_signed_value,
    output logic        o_byte_removed
);

    logic          r_h26x_mode;
    logic          w_req_valid, w_req_pop;
    bsr_pkg::t_req w_req;
    bsr_pkg::t_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h26x_mode <= 1'b0;
        else if (i_cfg_we) r_h26x_mode <= i_cfg_wdata;
    end

    bsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_bit_count (i_bit_count),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_pop   (w_req_pop)
    );

    bsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_h26x_mode (r_h26x_mode),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_pop   (w_req_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (w_res)
    );

    assign o_status       = w_res.status;
    assign o_value        = w_res.value;
    assign o_signed_value = w_res.signed_value;
    assign o_byte_removed = w_res.byte_removed;

    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_removed |-> o_status == bsr_pkg::ST_OK)
        else $error("removed byte with non-ok status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != bsr_pkg::ST_OK |-> o_value == 64'd0
            && o_signed_value == 32'sd0)
        else $error("failed transaction carries a value");

    a_signed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_signed_value != 32'sd0 |-> o_status == bsr_pkg::ST_OK
            && !o_byte_removed)
        else $error("signed value on non-se result");

endmodule
